/* src/fixed_block_free_list_allocator_core_defines.svh */
// Assertion macros shared by the allocator checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define FBFL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FBFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fbfl_pkg.sv */
// Shared types, constants and helpers of the free-list block allocator.
// No dependencies.
`timescale 1ns / 1ps

package fbfl_pkg;

    localparam int BLOCK_SLOTS = 256;
    localparam int IDX_W      = $clog2(BLOCK_SLOTS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int WORD_BYTES = 8;
    localparam int BYTES_W    = 16;
    localparam int ALIGN_W    = BYTES_W + 1;
    localparam int PROD_W     = IDX_W + ALIGN_W;
    localparam int ADDR_W     = 32;
    localparam int PADDR_W    = 4;

    localparam logic [LINK_W-1:0]  LINK_NONE  = LINK_W'(BLOCK_SLOTS);
    localparam logic [ALIGN_W-1:0] WORD_MASK  = ALIGN_W'(WORD_BYTES - 1);

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_BLOCK_COUNT = 2'd0;
    localparam reg_idx_t REG_BLOCK_BYTES = 2'd1;
    localparam reg_idx_t REG_POOL_BASE   = 2'd2;

    // live configuration seen by the datapath
    typedef struct packed {
        logic [LINK_W-1:0]  count;    // block_count limited to BLOCK_SLOTS
        logic [ALIGN_W-1:0] aligned;  // block size rounded up to a word
        logic [ADDR_W-1:0]  base;
    } cfg_t;

    // list rebuild request, count is the value after the write
    typedef struct packed {
        logic              req;
        logic [LINK_W-1:0] count;
    } rebuild_t;

    function automatic logic [LINK_W-1:0] active_count(input logic [8:0] bc);
        logic [LINK_W:0] wide;
        wide = (LINK_W+1)'(bc);
        if (wide > (LINK_W+1)'(BLOCK_SLOTS))
            return LINK_NONE;
        else
            return wide[LINK_W-1:0];
    endfunction

    // link an entry holds right after a rebuild
    function automatic logic [LINK_W-1:0] default_link(input logic [IDX_W-1:0] idx,
                                                      input logic [LINK_W-1:0] n);
        logic [LINK_W:0] succ;
        succ = (LINK_W+1)'(idx) + (LINK_W+1)'(1);
        if (succ < (LINK_W+1)'(n))
            return succ[LINK_W-1:0];
        else
            return LINK_NONE;
    endfunction

endpackage

/* src/fixed_block_free_list_allocator_core.sv */
// Top level of the fixed-size block allocator with a linked free list.
// Depends on fbfl_pkg, fbfl_ram and fbfl_cfg.
`timescale 1ns / 1ps

// Pool manager for equal-size blocks. A transaction is either an alloc
// (op = 0), which pops the head of the free list and returns its index and
// byte address, or a free (op = 1), which pushes block_index onto the list.
// A request is taken when start is high and busy is low; its result shows
// for exactly one cycle with done high, and the receiver cannot stall it,
// so it must sample every done cycle. A free, an out-of-range free and an
// alloc on an empty pool stay in S_IDLE: done rises in the cycle after
// acceptance and busy never rises, so these can be issued every cycle.
// A granted alloc holds busy through S_LOOKUP, which reads the link memory
// and registers the index times block size product, and S_ADDR, which
// forms the address and sets done. The link memory needs no
// clearing pass: per-entry valid bits, cleared at reset and by every
// configuration write, stand for the rebuilt ordered list. Configuration
// writes are allowed only while no request is outstanding.

module fixed_block_free_list_allocator_core
    import fbfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [IDX_W-1:0]   block_index,
    // result
    output logic               done,
    output status_t            status,
    output logic [IDX_W-1:0]   granted_index,
    output logic [ADDR_W-1:0]  granted_address,
    output logic [LINK_W-1:0]  free_count,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_ADDR   = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [LINK_W-1:0]  head_reg,  head_next;
    logic [LINK_W-1:0]  free_reg,  free_next;
    logic [BLOCK_SLOTS-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]   blk_reg,   blk_next;
    logic [PROD_W-1:0]  prod_reg,  prod_next;

    logic               done_reg,  done_next;
    status_t            status_reg, status_next;
    logic [IDX_W-1:0]   gidx_reg,  gidx_next;
    logic [ADDR_W-1:0]  gaddr_reg, gaddr_next;

    cfg_t               cfg;
    rebuild_t           rebuild;

    // link memory port
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [LINK_W-1:0]  mem_wdata;
    logic [LINK_W-1:0]  mem_rdata;
    logic [LINK_W-1:0]  link;
    logic               accept;

    fbfl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .rebuild (rebuild)
    );

    // next_link store; read address tracks the list head so the successor
    // of the head is ready the cycle after an alloc is taken
    fbfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (BLOCK_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (head_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start & ~busy;

    // entries untouched since the last rebuild read as the ordered list
    assign link = valid_reg[blk_reg] ? mem_rdata : default_link(blk_reg, cfg.count);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        free_next   = free_reg;
        valid_next  = valid_reg;
        blk_next    = blk_reg;
        prod_next   = prod_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        gidx_next   = gidx_reg;
        gaddr_next  = gaddr_reg;
        mem_we      = 1'b0;
        mem_waddr   = block_index;
        mem_wdata   = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (rebuild.req)
                begin
                    head_next  = (rebuild.count != '0) ? '0 : LINK_NONE;
                    free_next  = rebuild.count;
                    valid_next = '0;
                end
                else if (accept)
                begin
                    if (op)
                    begin
                        // free: push onto the head
                        done_next  = 1'b1;
                        gidx_next  = '0;
                        gaddr_next = '0;
                        if (LINK_W'(block_index) >= cfg.count)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            status_next             = ST_OK;
                            mem_we                  = 1'b1;
                            valid_next[block_index] = 1'b1;
                            head_next               = LINK_W'(block_index);
                            if (free_reg < cfg.count)
                            begin
                                free_next = free_reg + LINK_W'(1);
                            end
                        end
                    end
                    else if (head_reg == LINK_NONE)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_EMPTY;
                        gidx_next   = '0;
                        gaddr_next  = '0;
                    end
                    else
                    begin
                        blk_next   = head_reg[IDX_W-1:0];
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP:
            begin
                head_next = link;
                if (free_reg != '0)
                begin
                    free_next = free_reg - LINK_W'(1);
                end
                prod_next  = PROD_W'(blk_reg) * PROD_W'(cfg.aligned);
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                gidx_next   = blk_reg;
                gaddr_next  = cfg.base + ADDR_W'(WORD_BYTES) + ADDR_W'(prod_reg);
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            free_reg  <= LINK_W'(BLOCK_SLOTS);
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        blk_reg    <= blk_next;
        prod_reg   <= prod_next;
        status_reg <= status_next;
        gidx_reg   <= gidx_next;
        gaddr_reg  <= gaddr_next;
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_index   = gidx_reg;
    assign granted_address = gaddr_reg;
    assign free_count      = free_reg;

endmodule

/* src/fbfl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fbfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/fbfl_cfg.sv */
// APB-style configuration registers of the allocator.
// Depends on fbfl_pkg.
`timescale 1ns / 1ps

module fbfl_cfg
    import fbfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg,
    output rebuild_t           rebuild
);

    logic [8:0]         bcount_reg, bcount_next;
    logic [BYTES_W-1:0] bbytes_reg, bbytes_next;
    logic [ADDR_W-1:0]  base_reg,   base_next;
    logic               wr_en;
    reg_idx_t           ridx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign ridx   = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        bcount_next = bcount_reg;
        bbytes_next = bbytes_reg;
        base_next   = base_reg;
        rebuild.req = 1'b0;
        if (wr_en)
        begin
            unique case (ridx)
                REG_BLOCK_COUNT:
                begin
                    bcount_next = pwdata[8:0];
                    rebuild.req = 1'b1;
                end
                REG_BLOCK_BYTES:
                begin
                    bbytes_next = pwdata[BYTES_W-1:0];
                    rebuild.req = 1'b1;
                end
                REG_POOL_BASE:
                begin
                    base_next   = pwdata;
                    rebuild.req = 1'b1;
                end
                default: ;
            endcase
        end
        rebuild.count = active_count(bcount_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg <= 9'd256;
            bbytes_reg <= BYTES_W'(8);
            base_reg   <= '0;
        end
        else
        begin
            bcount_reg <= bcount_next;
            bbytes_reg <= bbytes_next;
            base_reg   <= base_next;
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_BLOCK_COUNT: prdata = 32'(bcount_reg);
            REG_BLOCK_BYTES: prdata = 32'(bbytes_reg);
            REG_POOL_BASE:   prdata = base_reg;
            default:         prdata = '0;
        endcase
    end

    assign cfg.count   = active_count(bcount_reg);
    assign cfg.aligned = (ALIGN_W'(bbytes_reg) + WORD_MASK) & ~WORD_MASK;
    assign cfg.base    = base_reg;

endmodule

/* src/fbfl_checker.sv */
// Port-level checker for the allocator, bound to the top level.
// Depends on fbfl_pkg and fixed_block_free_list_allocator_core_defines.svh.
`timescale 1ns / 1ps
`include "fixed_block_free_list_allocator_core_defines.svh"

module fbfl_checker
    import fbfl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               op,
    input logic               done,
    input status_t            status,
    input logic [IDX_W-1:0]   granted_index,
    input logic [ADDR_W-1:0]  granted_address,
    input logic [LINK_W-1:0]  free_count
);

    // no grant means zero index and address
    `FBFL_ASSERT_NOW(a_nogrant_zero, done && (status != ST_OK || op),
        (granted_index == '0) || (status == ST_OK), "non-grant with index")
    `FBFL_ASSERT_NOW(a_nogrant_addr, done && status != ST_OK,
        granted_index == '0 && granted_address == '0, "non-grant with payload")
    // frees complete in the cycle after acceptance
    `FBFL_ASSERT_NEXT(a_free_fast, start && !busy && op, done && !busy,
        "free result missing")
    // an alloc either completes at once or holds busy
    `FBFL_ASSERT_NEXT(a_alloc_prog, start && !busy && !op, done || busy,
        "alloc stalled")
    `FBFL_ASSERT_NOW(a_count_max, 1'b1, free_count <= LINK_W'(BLOCK_SLOTS),
        "free count above pool size")

endmodule

bind fixed_block_free_list_allocator_core fbfl_checker u_fbfl_checker (.*);
